/* src/esvg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esvg_pkg
// Shared types and constants of the ellipse strip vertex generator.
// ----------------------------------------------------------------------------
package esvg_pkg;

  localparam int unsigned SINE_DEPTH_DEF = 256;
  localparam int unsigned COORD_W_DEF    = 16;
  localparam int unsigned MAX_SEGMENTS   = 30;
  localparam int unsigned RUN_LIMIT      = 63;
  localparam int unsigned CMD_DEPTH      = 2;
  localparam int unsigned OUT_DEPTH      = 2;
  localparam longint unsigned PI_Q30     = 64'd3373259426;

  // pair limits so that a whole run fits in RUN_LIMIT vertices
  localparam logic [4:0] FIT_SINGLE = 5'((RUN_LIMIT - 3) / 2);
  localparam logic [4:0] FIT_DOUBLE = 5'((RUN_LIMIT - 4) / 2);
  localparam logic [4:0] SEG_MAX    = 5'(MAX_SEGMENTS);

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [4:0]         segs;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [15:0]        start;
    logic               lead2;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] slot;
    logic        last;
    logic        ovf;
  } attr_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DIV,
    B_OPEN,
    B_COS,
    B_MULX,
    B_MULY,
    B_UP,
    B_LO,
    B_CL1,
    B_CL2
  } back_state_e;

endpackage

/* src/esvg_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esvg_fifo
// Small register queue, used between front and back and on the result side.
// ----------------------------------------------------------------------------
module esvg_fifo import esvg_pkg::*; #(
  parameter type         T     = cmd_t,
  parameter int unsigned DEPTH = CMD_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output T     data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= nxt(wr_q);
      if (do_pop)  rd_q <= nxt(rd_q);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

/* src/esvg_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esvg_front
// Accepts ellipse items, picks the start slot, clamps the segment count and
// keeps the running vertex count of the strip.
// ----------------------------------------------------------------------------
module esvg_front import esvg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic signed [15:0] center_x_i,
  input  logic signed [15:0] center_y_i,
  input  logic signed [15:0] scale_x_i,
  input  logic signed [15:0] scale_y_i,
  input  logic [4:0]         segments_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         alpha_i,
  input  logic               place_at_index_i,
  input  logic [15:0]        start_index_i,
  input  logic               cmd_full_i,
  output logic               cmd_push_o,
  output cmd_t               cmd_o
);

  logic [15:0] count_q, count_d;
  logic [15:0] start;
  logic        lead2;
  logic [4:0]  fit, n_lim, n;
  logic [6:0]  run_len;

  always_comb begin
    start   = place_at_index_i ? start_index_i : count_q;
    lead2   = (start != '0);
    fit     = lead2 ? FIT_DOUBLE : FIT_SINGLE;
    n_lim   = (SEG_MAX < fit) ? SEG_MAX : fit;
    n       = (segments_i > n_lim) ? n_lim : segments_i;
    run_len = 7'({n, 1'b0}) + 7'd3 + 7'(lead2);
    cmd_push_o = push_i && !cmd_full_i;
    count_d = count_q;
    if (cmd_push_o && !place_at_index_i) count_d = start + 16'(run_len);

    cmd_o.cx    = center_x_i;
    cmd_o.cy    = center_y_i;
    cmd_o.sx    = scale_x_i;
    cmd_o.sy    = scale_y_i;
    cmd_o.segs  = n;
    cmd_o.red   = red_i;
    cmd_o.green = green_i;
    cmd_o.blue  = blue_i;
    cmd_o.alpha = alpha_i;
    cmd_o.start = start;
    cmd_o.lead2 = lead2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else         count_q <= count_d;
  end

endmodule

/* src/esvg_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esvg_back
// Walks one ellipse: angle-step division, phase accumulation, sine lookup,
// scaling and saturation, one vertex per emit cycle.
// ----------------------------------------------------------------------------
module esvg_back import esvg_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
  parameter int unsigned COORD_WIDTH      = COORD_W_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  cmd_t                   cmd_i,
  output logic                   cmd_pop_o,
  input  logic                   out_full_i,
  output logic                   emit_o,
  output logic [COORD_WIDTH-1:0] vert_x_o,
  output logic [COORD_WIDTH-1:0] vert_y_o,
  output attr_t                  attr_o
);

  localparam int unsigned AW   = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned DW   = AW + 3;
  localparam int unsigned CNTW = $clog2(DW + 1);
  localparam int unsigned SW   = 34;
  localparam logic [DW-1:0] DIVIDEND = DW'(4 * SINE_TABLE_DEPTH);
  localparam logic [DW-1:0] DEPTH_P  = DW'(SINE_TABLE_DEPTH);
  localparam logic [DW-1:0] TWO_D    = DW'(2 * SINE_TABLE_DEPTH);
  localparam logic signed [SW-1:0] SAT_HI =
    $signed(SW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1));
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [SW-1:0] HALF = SW'(16384);

  // quarter-wave sine, Q1.15, worked out at elaboration
  logic [15:0] sine_rom [SINE_TABLE_DEPTH];
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam longint unsigned X =
      (64'(k) * PI_Q30 + 64'(SINE_TABLE_DEPTH)) / (64'd2 * 64'(SINE_TABLE_DEPTH));
    localparam longint unsigned X2 = (X * X) >> 30;
    localparam longint unsigned T1 = ((X * X2) >> 30) / 6;
    localparam longint unsigned T2 = ((T1 * X2) >> 30) / 20;
    localparam longint unsigned T3 = ((T2 * X2) >> 30) / 42;
    localparam longint unsigned T4 = ((T3 * X2) >> 30) / 72;
    localparam longint unsigned T5 = ((T4 * X2) >> 30) / 110;
    localparam longint unsigned T6 = ((T5 * X2) >> 30) / 156;
    localparam longint unsigned T7 = ((T6 * X2) >> 30) / 210;
    localparam longint S = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                         + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7);
    localparam longint S0 = (S < 0) ? 0 : S;
    localparam longint V  = (S0 + 16384) >>> 15;
    localparam longint VC = (V > 65535) ? 65535 : V;
    assign sine_rom[k] = 16'(VC);
  end

  back_state_e state_q, state_d;
  cmd_t              cmd_q;
  logic [5:0]        k_q;
  logic [4:0]        pair_q;
  logic [6:0]        rem_q;
  logic [DW-1:0]     dvd_q, quo_q, p_q;
  logic [CNTW-1:0]   dcnt_q;
  logic [5:0]        div_q;
  logic [6:0]        prem_q;
  logic [16:0]       rom_q;
  logic              neg_q;
  logic signed [SW-1:0] mul_q;
  logic signed [17:0]   dx_q, dy_q;

  logic [6:0]        rem_sh, rem_nx, psum, prem_nx;
  logic              ge, carry, upper;
  logic [DW-1:0]     cos_idx, sin_idx, rd_idx;
  logic signed [17:0]   fac, dy_now;
  logic signed [SW-1:0] term, cx_w, cy_w, sx_w, x_sum, y_sum;
  logic [16:0]       slot_full;

  function automatic logic [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
    if (v > SAT_HI) return SAT_HI[COORD_WIDTH-1:0];
    if (v < SAT_LO) return SAT_LO[COORD_WIDTH-1:0];
    return v[COORD_WIDTH-1:0];
  endfunction

  always_comb begin
    // restoring divider, one quotient bit a cycle
    rem_sh  = {rem_q[5:0], dvd_q[DW-1]};
    ge      = (rem_sh >= {1'b0, div_q});
    rem_nx  = ge ? rem_sh - {1'b0, div_q} : rem_sh;
    // phase step: p += Q, remainder += R with one carry back
    psum    = prem_q + rem_q;
    carry   = (psum >= {1'b0, div_q});
    prem_nx = carry ? psum - {1'b0, div_q} : psum;
    upper   = (p_q > DEPTH_P);
    cos_idx = upper ? p_q - DEPTH_P : DEPTH_P - p_q;
    sin_idx = upper ? TWO_D - p_q : p_q;
    rd_idx  = (state_q == B_COS) ? cos_idx : sin_idx;
    fac     = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
    term    = (mul_q + HALF) >>> 15;
    dy_now  = $signed(term[17:0]);
    cx_w    = SW'(cmd_q.cx);
    cy_w    = SW'(cmd_q.cy);
    sx_w    = SW'(cmd_q.sx);
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    emit_o    = 1'b0;
    x_sum     = cx_w;
    y_sum     = cy_w;
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = B_DIV;
        end
      end
      B_DIV: begin
        if (dcnt_q == CNTW'(DW - 1)) state_d = B_OPEN;
      end
      B_OPEN: begin
        x_sum  = cx_w + sx_w;
        emit_o = !out_full_i;
        if (emit_o && k_q == {5'b0, cmd_q.lead2})
          state_d = (cmd_q.segs == '0) ? B_CL1 : B_COS;
      end
      B_COS:  state_d = B_MULX;
      B_MULX: state_d = B_MULY;
      B_MULY: state_d = B_UP;
      B_UP: begin
        x_sum  = cx_w + SW'(dx_q);
        y_sum  = cy_w + SW'(dy_now);
        emit_o = !out_full_i;
        if (emit_o) state_d = B_LO;
      end
      B_LO: begin
        x_sum  = cx_w + SW'(dx_q);
        y_sum  = cy_w - SW'(dy_q);
        emit_o = !out_full_i;
        if (emit_o) state_d = (pair_q == cmd_q.segs - 5'd1) ? B_CL1 : B_COS;
      end
      B_CL1: begin
        x_sum  = cx_w - sx_w;
        emit_o = !out_full_i;
        if (emit_o) state_d = B_CL2;
      end
      B_CL2: begin
        x_sum  = cx_w - sx_w;
        emit_o = !out_full_i;
        if (emit_o) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= B_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      pair_q <= '0;
      dcnt_q <= '0;
    end else begin
      if (cmd_pop_o) begin
        k_q    <= '0;
        pair_q <= '0;
        dcnt_q <= '0;
      end else begin
        if (state_q == B_DIV) dcnt_q <= dcnt_q + CNTW'(1);
        if (emit_o) k_q <= k_q + 6'd1;
        if (emit_o && state_q == B_LO) pair_q <= pair_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rom_q <= (rd_idx == DEPTH_P) ? 17'd32768 : {1'b0, sine_rom[rd_idx[AW-1:0]]};
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
      rem_q <= '0;
      dvd_q <= DIVIDEND;
      quo_q <= '0;
      div_q <= {cmd_i.segs, 1'b0};
    end
    if (state_q == B_DIV) begin
      rem_q <= rem_nx;
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      quo_q <= {quo_q[DW-2:0], ge};
      p_q    <= '0;
      prem_q <= {2'b0, cmd_q.segs};
    end
    if (state_q == B_COS)  neg_q <= upper;
    if (state_q == B_MULX) mul_q <= SW'(cmd_q.sx) * SW'(fac);
    if (state_q == B_MULY) begin
      dx_q  <= $signed(term[17:0]);
      mul_q <= SW'(cmd_q.sy) * SW'($signed({1'b0, rom_q}));
    end
    if (state_q == B_UP && emit_o) begin
      dy_q   <= dy_now;
      p_q    <= p_q + quo_q + DW'(carry);
      prem_q <= prem_nx;
    end
  end

  always_comb begin
    slot_full    = {1'b0, cmd_q.start} + 17'(k_q);
    vert_x_o     = sat(x_sum);
    vert_y_o     = sat(y_sum);
    attr_o.red   = cmd_q.red;
    attr_o.green = cmd_q.green;
    attr_o.blue  = cmd_q.blue;
    attr_o.alpha = cmd_q.alpha;
    attr_o.slot  = slot_full[15:0];
    attr_o.ovf   = slot_full[16];
    attr_o.last  = (state_q == B_CL2);
  end

endmodule

/* src/ellipse_strip_vertex_generator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_strip_vertex_generator_core
// Turns ellipse items into triangle-strip vertex runs with color and slot.
// ----------------------------------------------------------------------------
// The first vertex follows the angle-step division after accept. Ellipses
// are taken one at a time by the back sequencer: the division, lead vertices
// (lead is 1 or 2), n angle pairs and two closing vertices; each angle pair
// takes a lookup, two multiplies and two emits. The sequencer sets the rate.
// Reset clears the vertex count and both queues; the sine table is constant.
module ellipse_strip_vertex_generator_core import esvg_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
  parameter int unsigned COORD_WIDTH      = COORD_W_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic signed [15:0]     center_x_i,
  input  logic signed [15:0]     center_y_i,
  input  logic signed [15:0]     scale_x_i,
  input  logic signed [15:0]     scale_y_i,
  input  logic [4:0]             segments_i,
  input  logic [7:0]             red_i,
  input  logic [7:0]             green_i,
  input  logic [7:0]             blue_i,
  input  logic [7:0]             alpha_i,
  input  logic                   place_at_index_i,
  input  logic [15:0]            start_index_i,
  output logic                   empty,
  input  logic                   pop,
  output logic signed [COORD_WIDTH-1:0] vert_x_o,
  output logic signed [COORD_WIDTH-1:0] vert_y_o,
  output logic [7:0]             out_red_o,
  output logic [7:0]             out_green_o,
  output logic [7:0]             out_blue_o,
  output logic [7:0]             out_alpha_o,
  output logic [15:0]            vertex_slot_o,
  output logic                   last_vertex_o,
  output logic                   slot_overflow_o
);

  typedef struct packed {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    attr_t                  attr;
  } vert_t;

  cmd_t  cmd_w, cmd_head_w;
  logic  cmd_push_w, cmd_full_w, cmd_empty_w, cmd_pop_w;
  logic  emit_w, out_full_w;
  logic [COORD_WIDTH-1:0] bx_w, by_w;
  attr_t battr_w;
  vert_t vin_w, vout_w;

  esvg_front u_front (
    .clk_i, .rst_ni,
    .push_i           (push),
    .center_x_i, .center_y_i, .scale_x_i, .scale_y_i, .segments_i,
    .red_i, .green_i, .blue_i, .alpha_i, .place_at_index_i, .start_index_i,
    .cmd_full_i       (cmd_full_w),
    .cmd_push_o       (cmd_push_w),
    .cmd_o            (cmd_w)
  );

  assign full = cmd_full_w;

  esvg_fifo #(.T(cmd_t), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk_i, .rst_ni,
    .push_i  (cmd_push_w),
    .data_i  (cmd_w),
    .full_o  (cmd_full_w),
    .pop_i   (cmd_pop_w),
    .empty_o (cmd_empty_w),
    .data_o  (cmd_head_w)
  );

  esvg_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .COORD_WIDTH      (COORD_WIDTH)
  ) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (!cmd_empty_w),
    .cmd_i       (cmd_head_w),
    .cmd_pop_o   (cmd_pop_w),
    .out_full_i  (out_full_w),
    .emit_o      (emit_w),
    .vert_x_o    (bx_w),
    .vert_y_o    (by_w),
    .attr_o      (battr_w)
  );

  assign vin_w = '{x: bx_w, y: by_w, attr: battr_w};

  esvg_fifo #(.T(vert_t), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk_i, .rst_ni,
    .push_i  (emit_w),
    .data_i  (vin_w),
    .full_o  (out_full_w),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (vout_w)
  );

  assign vert_x_o        = $signed(vout_w.x);
  assign vert_y_o        = $signed(vout_w.y);
  assign out_red_o       = vout_w.attr.red;
  assign out_green_o     = vout_w.attr.green;
  assign out_blue_o      = vout_w.attr.blue;
  assign out_alpha_o     = vout_w.attr.alpha;
  assign vertex_slot_o   = vout_w.attr.slot;
  assign last_vertex_o   = vout_w.attr.last;
  assign slot_overflow_o = vout_w.attr.ovf;

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_w |-> !out_full_w)
    else $error("vertex emitted into a full result queue");

  a_seg_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push_w |-> (cmd_w.segs <= (cmd_w.lead2 ? FIT_DOUBLE : FIT_SINGLE)))
    else $error("segment count exceeds run limit");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_w |-> !cmd_empty_w)
    else $error("back took an item from an empty command queue");

endmodule
